// ----- rtl/ddol_pkg.sv -----
package ddol_pkg;

  // Frame framing bytes of the odometry link.
  localparam logic [7:0] HDR_BYTE  = 8'h33;
  localparam logic [7:0] TAIL_BYTE = 8'h99;

  // Direction codes (ASCII).
  localparam logic [7:0] DIR_FWD        = 8'h46;  // F
  localparam logic [7:0] DIR_BACK       = 8'h42;  // B
  localparam logic [7:0] DIR_LEFT       = 8'h4C;  // L
  localparam logic [7:0] DIR_LEFT_SOFT  = 8'h6C;  // l
  localparam logic [7:0] DIR_RIGHT      = 8'h52;  // R
  localparam logic [7:0] DIR_RIGHT_SOFT = 8'h72;  // r
  localparam logic [7:0] DIR_STOP       = 8'h53;  // S

  localparam int DIV_BITS   = 32;
  localparam int DVSR_BITS  = 14;
  localparam int CNT_BITS   = 5;
  localparam logic [DVSR_BITS-1:0] FULL_TURN = 14'd360;
  localparam logic [3:0] LAST_FRAME_IDX = 4'd9;
  localparam logic signed [21:0] HEAD_STEP_MIN = 22'sd5;
  localparam logic signed [21:0] MOVE_STEP_MIN = 22'sd3;

  // Reciprocal of a full turn scaled by 2^30 and rounded up. The floor of the
  // scaled product is the exact quotient for every dividend below 2^21.
  localparam int HEAD_RECIP_SHIFT = 30;
  localparam logic [21:0] HEAD_RECIP = 22'd2982617;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CHECK,
    ST_MOD_WAIT,
    ST_EMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_latch;
    logic mod_start;
    logic mod_latch;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_good;
    logic out_free;
    logic div_done;
    logic mod_done;
    logic need_mod;
  } dp_status_t;

  // Speed bucket: speed/10 saturated at 10.
  function automatic logic [3:0] speed_index(input logic [6:0] spd);
    logic [3:0] idx;
    idx = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if (spd >= 7'(k * 10)) begin
        idx = 4'(k);
      end
    end
    return idx;
  endfunction

  function automatic logic [12:0] dist_gain_lut(input logic [3:0] idx);
    logic [12:0] g;
    case (idx)
      4'd3:    g = 13'd4100;
      4'd4:    g = 13'd3900;
      4'd5:    g = 13'd3600;
      4'd6:    g = 13'd3300;
      4'd7:    g = 13'd2700;
      4'd8:    g = 13'd1850;
      4'd9:    g = 13'd1350;
      4'd10:   g = 13'd900;
      default: g = 13'd0;
    endcase
    return g;
  endfunction

  function automatic logic [10:0] turn_gain_lut(input logic [3:0] idx);
    logic [10:0] g;
    case (idx)
      4'd5:    g = 11'd1700;
      4'd6:    g = 11'd1100;
      4'd7:    g = 11'd1000;
      4'd8:    g = 11'd900;
      4'd9:    g = 11'd800;
      4'd10:   g = 11'd700;
      default: g = 11'd0;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/ddol_div.sv -----
module ddol_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ddol_pkg::DIV_BITS-1:0]  dividend,
  input  logic [ddol_pkg::DVSR_BITS-1:0] divisor,
  output logic [ddol_pkg::DIV_BITS-1:0]  quotient,
  output logic [ddol_pkg::DVSR_BITS-1:0] remainder,
  output logic                           done
);
  import ddol_pkg::*;

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [DVSR_BITS-1:0] dvsr;
  logic [DVSR_BITS:0]   trial;
  logic                 fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {remainder, quotient[DIV_BITS-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_BITS'(DIV_BITS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(DIV_BITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvsr      <= divisor;
    end else if (busy) begin
      if (fits) begin
        remainder <= DVSR_BITS'(trial - {1'b0, dvsr});
      end else begin
        remainder <= trial[DVSR_BITS-1:0];
      end
      quotient <= {quotient[DIV_BITS-2:0], fits};
    end
  end

endmodule

// ----- rtl/ddol_dp.sv -----
module ddol_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  ddol_pkg::ctrl_cmd_t     cmd,
  output ddol_pkg::dp_status_t    status,
  input  logic                    operation,
  input  logic [7:0]              rx_byte,
  input  logic [7:0]              direction_cmd,
  input  logic [6:0]              speed,
  input  logic [15:0]             distance,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    motor_valid,
  output logic signed [7:0]       motor_left,
  output logic signed [7:0]       motor_right,
  output logic                    limit_hit,
  output logic                    heading_valid,
  output logic [8:0]              heading,
  output logic                    move_valid,
  output logic signed [21:0]      move_distance,
  output logic [7:0]              current_direction
);
  import ddol_pkg::*;

  // Architectural state.
  logic [3:0]  frame_count;
  logic [7:0]  frame_bytes [8];
  logic [31:0] accum_left, accum_right;
  logic [31:0] limit_left, limit_right;
  logic        limit_armed;
  logic [12:0] dist_gain;
  logic [10:0] turn_gain;
  logic [8:0]  heading_deg;
  logic [7:0]  drive_direction;

  // Frame work registers.
  logic [31:0]        diff_w, sum_w;
  logic               hit_r, hv_r;
  logic signed [21:0] ang_r, dst_r;

  // Command decode.
  logic [3:0]  idx;
  logic [12:0] dk;
  logic [10:0] ak;
  logic        gain_zero;
  logic [12:0] mul_gain;
  logic [28:0] prod;
  logic [31:0] prod_pos, prod_neg;
  logic [7:0]  sp, sp_neg, sp_half;
  logic        dir_known;
  logic [31:0] ll, lr;
  logic [7:0]  ml, mr;

  assign idx       = speed_index(speed);
  assign dk        = dist_gain_lut(idx);
  assign ak        = turn_gain_lut(idx);
  assign gain_zero = (dk == '0) || (ak == '0);
  assign mul_gain  = (direction_cmd == DIR_LEFT || direction_cmd == DIR_RIGHT) ?
                     {2'b00, ak} : dk;
  assign prod      = distance * mul_gain;
  assign prod_pos  = {3'b000, prod};
  assign prod_neg  = 32'(-prod_pos);
  assign sp        = {1'b0, speed};
  assign sp_neg    = 8'(-sp);
  assign sp_half   = {2'b00, speed[6:1]};

  // Per-direction drive pair and wheel limits.
  always_comb begin
    dir_known = 1'b1;
    ll = '0;
    lr = '0;
    ml = '0;
    mr = '0;
    case (direction_cmd)
      DIR_FWD:        begin ml = sp;     mr = sp;      ll = prod_pos; lr = prod_pos; end
      DIR_BACK:       begin ml = sp_neg; mr = sp_neg;  ll = prod_neg; lr = prod_neg; end
      DIR_LEFT:       begin ml = sp_neg; mr = sp;      ll = prod_neg; lr = prod_pos; end
      DIR_LEFT_SOFT:  begin ml = sp_half; mr = sp;     ll = '0;       lr = prod_pos; end
      DIR_RIGHT:      begin ml = sp;     mr = sp_neg;  ll = prod_pos; lr = prod_neg; end
      DIR_RIGHT_SOFT: begin ml = sp;     mr = sp_half; ll = prod_pos; lr = '0;       end
      default:        dir_known = 1'b0;
    endcase
  end

  // Frame assembly.
  logic [31:0] m1, m2, acc_l_new, acc_r_new;
  logic        trip_l, trip_r;

  assign m1 = {frame_bytes[0], frame_bytes[1], frame_bytes[2], frame_bytes[3]};
  assign m2 = {frame_bytes[4], frame_bytes[5], frame_bytes[6], frame_bytes[7]};
  assign acc_l_new = accum_left + m1;
  assign acc_r_new = accum_right + m2;
  assign trip_l = (limit_left != '0) &&
                  ((!limit_left[31] && ($signed(acc_l_new) > $signed(limit_left))) ||
                   (limit_left[31] && ($signed(acc_l_new) < $signed(limit_left))));
  assign trip_r = (limit_right != '0) &&
                  ((!limit_right[31] && ($signed(acc_r_new) > $signed(limit_right))) ||
                   (limit_right[31] && ($signed(acc_r_new) < $signed(limit_right))));

  // Divider operands: magnitudes, signs applied afterwards.
  logic [31:0]        diff_mag, sum_mag;
  logic signed [22:0] head_sum;
  logic [21:0]        head_mag;
  logic [31:0]        q_a, q_b;
  logic [13:0]        r_a, r_b;
  logic               done_a, done_b;
  logic [21:0]        q_a_mag, q_b_mag;

  assign diff_mag = diff_w[31] ? 32'(-diff_w) : diff_w;
  assign sum_mag  = sum_w[31] ? 32'(-sum_w) : sum_w;
  assign head_sum = $signed({14'b0, heading_deg}) + 23'(ang_r);
  assign head_mag = head_sum[22] ? 22'(-head_sum) : head_sum[21:0];
  assign q_a_mag  = q_a[21:0];
  assign q_b_mag  = q_b[21:0];

  ddol_div u_div_a (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (diff_mag),
    .divisor   ({2'b00, turn_gain, 1'b0}),
    .quotient  (q_a),
    .remainder (r_a),
    .done      (done_a)
  );

  ddol_div u_div_b (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (sum_mag),
    .divisor   ({dist_gain, 1'b0}),
    .quotient  (q_b),
    .remainder (r_b),
    .done      (done_b)
  );

  // Heading wrap: quotient by reciprocal multiply, remainder the cycle after.
  logic [43:0] mod_prod;
  logic [13:0] mod_q;
  logic        mod_pend;
  logic [21:0] mod_rem_w;
  logic [8:0]  mod_rem;

  assign mod_prod  = {22'b0, head_mag} * {22'b0, HEAD_RECIP};
  assign mod_rem_w = head_mag - {8'b0, mod_q} * 22'(FULL_TURN);
  assign mod_rem   = mod_rem_w[8:0];

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  assign status.frame_good = !operation && (frame_count == LAST_FRAME_IDX) &&
                             (rx_byte == TAIL_BYTE);
  assign status.out_free   = out_free;
  assign status.div_done   = done_a;
  assign status.mod_done   = mod_pend;
  assign status.need_mod   = (ang_r > HEAD_STEP_MIN) || (ang_r < -HEAD_STEP_MIN);

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count     <= '0;
      accum_left      <= '0;
      accum_right     <= '0;
      limit_left      <= '0;
      limit_right     <= '0;
      limit_armed     <= 1'b0;
      dist_gain       <= '0;
      turn_gain       <= '0;
      heading_deg     <= '0;
      drive_direction <= DIR_STOP;
      out_valid       <= 1'b0;
      mod_pend        <= 1'b0;
    end else begin
      // A result stays until taken; commands and frame ends load a new one.
      out_valid <= (out_valid && out_stall) || (cmd.accept && operation) || cmd.emit;
      mod_pend  <= cmd.mod_start;
      if (cmd.accept && operation) begin
        // Motion command: always one transfer.
        if (gain_zero || !dir_known) begin
          drive_direction <= DIR_STOP;
          limit_armed     <= 1'b0;
        end else begin
          drive_direction <= direction_cmd;
          limit_armed     <= 1'b1;
          limit_left      <= ll;
          limit_right     <= lr;
        end
        if (!gain_zero) begin
          accum_left  <= '0;
          accum_right <= '0;
          dist_gain   <= dk;
          turn_gain   <= ak;
        end
      end else if (cmd.accept) begin
        // Odometry byte: frame counter.
        if (frame_count != '0 || rx_byte == HDR_BYTE) begin
          frame_count <= (frame_count == LAST_FRAME_IDX) ? '0 : frame_count + 1'b1;
        end
        if (status.frame_good) begin
          accum_left  <= acc_l_new;
          accum_right <= acc_r_new;
          if (limit_armed && (trip_l || trip_r)) begin
            drive_direction <= DIR_STOP;
            limit_armed     <= 1'b0;
          end
        end
      end
      if (cmd.mod_latch) begin
        if (head_sum[22] && mod_rem != '0) begin
          heading_deg <= 9'(FULL_TURN - {5'b0, mod_rem});
        end else begin
          heading_deg <= mod_rem;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept && !operation && frame_count != '0 && frame_count != LAST_FRAME_IDX) begin
      frame_bytes[3'(frame_count - 1'b1)] <= rx_byte;
    end
    if (cmd.accept && status.frame_good) begin
      diff_w <= m1 - m2;
      sum_w  <= m1 + m2;
      hit_r  <= limit_armed && (trip_l || trip_r);
      hv_r   <= 1'b0;
    end
    if (cmd.div_latch) begin
      ang_r <= (turn_gain == '0) ? '0 : (diff_w[31] ? 22'(-q_a_mag) : q_a_mag);
      dst_r <= (dist_gain == '0) ? '0 : (sum_w[31] ? 22'(-q_b_mag) : q_b_mag);
    end
    if (cmd.mod_start) begin
      mod_q <= mod_prod[HEAD_RECIP_SHIFT +: 14];
    end
    if (cmd.mod_latch) begin
      hv_r <= 1'b1;
    end
    if (cmd.accept && operation) begin
      motor_valid       <= 1'b1;
      motor_left        <= (gain_zero || !dir_known) ? '0 : ml;
      motor_right       <= (gain_zero || !dir_known) ? '0 : mr;
      limit_hit         <= 1'b0;
      heading_valid     <= 1'b0;
      heading           <= heading_deg;
      move_valid        <= 1'b0;
      move_distance     <= '0;
      current_direction <= (gain_zero || !dir_known) ? DIR_STOP : direction_cmd;
    end else if (cmd.emit) begin
      motor_valid       <= hit_r;
      motor_left        <= '0;
      motor_right       <= '0;
      limit_hit         <= hit_r;
      heading_valid     <= hv_r;
      heading           <= heading_deg;
      move_valid        <= (dst_r > MOVE_STEP_MIN) || (dst_r < -MOVE_STEP_MIN);
      move_distance     <= dst_r;
      current_direction <= drive_direction;
    end
  end

endmodule

// ----- rtl/ddol_ctrl.sv -----
module ddol_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ddol_pkg::dp_status_t status,
  output ddol_pkg::ctrl_cmd_t  cmd
);
  import ddol_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = !status.out_free;
        if (in_valid && status.out_free) begin
          cmd.accept = 1'b1;
          if (status.frame_good) begin
            state_next = ST_DIV_START;
          end
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_latch = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.need_mod) begin
          cmd.mod_start = 1'b1;
          state_next    = ST_MOD_WAIT;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_MOD_WAIT: begin
        if (status.mod_done) begin
          cmd.mod_latch = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/diff_drive_odometry_limiter.sv -----
// A command's transfer is offered from the cycle after it is taken. A frame-closing byte
// starts the frame work: two 32-step radix-2 dividers run side by side, then a heading
// wrap if the heading moves by more than five degrees, then the transfer is offered.
// Throughput is one item per cycle except during that frame work or while a result waits.
// Synchronous reset clears the frame counter, wheel accumulators, limits, gains and
// heading and sets the direction to stop.
module diff_drive_odometry_limiter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         direction_cmd,
  input  logic [6:0]         speed,
  input  logic [15:0]        distance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               motor_valid,
  output logic signed [7:0]  motor_left,
  output logic signed [7:0]  motor_right,
  output logic               limit_hit,
  output logic               heading_valid,
  output logic [8:0]         heading,
  output logic               move_valid,
  output logic signed [21:0] move_distance,
  output logic [7:0]         current_direction
);
  import ddol_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ddol_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ddol_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .operation         (operation),
    .rx_byte           (rx_byte),
    .direction_cmd     (direction_cmd),
    .speed             (speed),
    .distance          (distance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .motor_valid       (motor_valid),
    .motor_left        (motor_left),
    .motor_right       (motor_right),
    .limit_hit         (limit_hit),
    .heading_valid     (heading_valid),
    .heading           (heading),
    .move_valid        (move_valid),
    .move_distance     (move_distance),
    .current_direction (current_direction)
  );

endmodule

// ----- rtl/ddol_checker.sv -----
module ddol_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic              motor_valid,
  input logic signed [7:0] motor_left,
  input logic signed [7:0] motor_right,
  input logic              limit_hit,
  input logic [8:0]        heading,
  input logic [7:0]        current_direction
);
  import ddol_pkg::*;

  // A stalled transfer holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(heading) && $stable(limit_hit))
    else $error("stalled result changed");

  // Heading stays within one turn.
  a_heading: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading < 9'd360)
    else $error("heading out of range");

  // A limit trip stops both motors.
  a_trip: assert property (@(posedge clk) disable iff (rst)
    out_valid && limit_hit |-> motor_valid && motor_left == 8'sd0 &&
      motor_right == 8'sd0 && current_direction == DIR_STOP)
    else $error("limit trip without stop");

  // No drive pair means zero drive.
  a_idle_motor: assert property (@(posedge clk) disable iff (rst)
    out_valid && !motor_valid |-> motor_left == 8'sd0 && motor_right == 8'sd0)
    else $error("drive without motor transfer");

endmodule

bind diff_drive_odometry_limiter ddol_checker u_ddol_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .motor_valid       (motor_valid),
  .motor_left        (motor_left),
  .motor_right       (motor_right),
  .limit_hit         (limit_hit),
  .heading           (heading),
  .current_direction (current_direction)
);
